// File: sv/tgs_pkg.sv
`timescale 1ns / 1ps
// shared constants and the reciprocal table for the triangle grid subdivider
// no dependencies

package tgs_pkg;

    localparam int MAX_DETAIL = 3;
    localparam int COORD_BITS = 16;
    localparam int DET_BITS   = 2;

    // floor(2^sh / (2*rows)) for the small row divisors of the grid
    function automatic logic [63:0] f_recip(input logic [7:0] rows, input int unsigned sh);
        logic [63:0] one;
        logic [63:0] m;
        one = 64'd1 << sh;
        case (rows)
            8'd1:    m = one / 2;
            8'd2:    m = one / 4;
            8'd3:    m = one / 6;
            8'd4:    m = one / 8;
            8'd5:    m = one / 10;
            8'd6:    m = one / 12;
            8'd7:    m = one / 14;
            8'd8:    m = one / 16;
            default: m = one / 2;
        endcase
        return m;
    endfunction

endpackage

// File: sv/tgs_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces: input triangle and output sub-triangle
// depends on tgs_pkg

interface tgs_tri_if #(parameter int CW = tgs_pkg::COORD_BITS);
    logic valid;
    logic ready;
    logic signed [CW-1:0] a_x, a_y, a_z;
    logic signed [CW-1:0] b_x, b_y, b_z;
    logic signed [CW-1:0] c_x, c_y, c_z;

    modport source(output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   input ready);
    modport sink(input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                 output ready);
endinterface

interface tgs_sub_if #(parameter int CW = tgs_pkg::COORD_BITS);
    logic valid;
    logic ready;
    logic signed [CW-1:0] p0_x, p0_y, p0_z;
    logic signed [CW-1:0] p1_x, p1_y, p1_z;
    logic signed [CW-1:0] p2_x, p2_y, p2_z;
    logic last_of_face;

    modport source(output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                   p2_x, p2_y, p2_z, last_of_face, input ready);
    modport sink(input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                 p2_x, p2_y, p2_z, last_of_face, output ready);
endinterface

// File: sv/tgs_seq.sv
`timescale 1ns / 1ps
// sequencer: holds one triangle and walks its sub-triangles one per cycle while i_adv is high
// depends on tgs_pkg, tgs_if

module tgs_seq #(
    parameter int COORD_BITS = tgs_pkg::COORD_BITS,
    parameter int MAX_DETAIL = tgs_pkg::MAX_DETAIL
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [tgs_pkg::DET_BITS-1:0]  i_cfg_wr_data,
    tgs_tri_if.sink                       i_tri,
    input  logic                          i_adv,
    output logic                          o_issue,
    output logic                          o_last,
    output logic [tgs_pkg::DET_BITS-1:0]  o_det,
    output logic signed [COORD_BITS-1:0]  o_a [3],
    output logic signed [COORD_BITS-1:0]  o_b [3],
    output logic signed [COORD_BITS-1:0]  o_c [3],
    output logic [MAX_DETAIL:0]           o_pt_i [3],
    output logic [MAX_DETAIL:0]           o_pt_j [3]
);

    localparam int DW = tgs_pkg::DET_BITS;
    localparam int IW = MAX_DETAIL + 1;

    logic                  r_busy;
    logic [DW-1:0]         r_det;
    logic [IW-1:0]         r_i;
    logic [IW-1:0]         r_s;
    logic signed [COORD_BITS-1:0] r_a [3];
    logic signed [COORD_BITS-1:0] r_b [3];
    logic signed [COORD_BITS-1:0] r_c [3];

    logic [IW-1:0] w_cols;
    logic [IW-1:0] w_rows;
    logic [IW:0]   w_slot_end;
    logic [IW-1:0] w_k;
    logic          w_last;
    logic          w_accept;

    assign w_cols     = IW'(1) << r_det;
    assign w_rows     = w_cols - r_i;
    assign w_slot_end = {w_rows, 1'b0} - (IW+1)'(2);
    assign w_k        = r_s >> 1;
    assign w_last     = (r_i == w_cols - IW'(1));

    assign o_issue     = r_busy && i_adv;
    assign o_last      = w_last;
    assign o_det       = r_det;
    assign i_tri.ready = !r_busy || (i_adv && w_last);
    assign w_accept    = i_tri.valid && i_tri.ready;

    assign o_a = r_a;
    assign o_b = r_b;
    assign o_c = r_c;

    // even slot: (i,k+1) (i+1,k) (i,k); odd slot: (i,k+1) (i+1,k+1) (i+1,k)
    always_comb begin
        o_pt_i[0] = r_i;
        o_pt_j[0] = w_k + IW'(1);
        o_pt_i[1] = r_i + IW'(1);
        o_pt_j[1] = r_s[0] ? w_k + IW'(1) : w_k;
        o_pt_i[2] = r_s[0] ? r_i + IW'(1) : r_i;
        o_pt_j[2] = w_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_det  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_det <= (int'(i_cfg_wr_data) > MAX_DETAIL) ? DW'(MAX_DETAIL) : i_cfg_wr_data;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_s    <= '0;
                r_a[0] <= i_tri.a_x;
                r_a[1] <= i_tri.a_y;
                r_a[2] <= i_tri.a_z;
                r_b[0] <= i_tri.b_x;
                r_b[1] <= i_tri.b_y;
                r_b[2] <= i_tri.b_z;
                r_c[0] <= i_tri.c_x;
                r_c[1] <= i_tri.c_y;
                r_c[2] <= i_tri.c_z;
            end else if (o_issue) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                end else if ({1'b0, r_s} == w_slot_end) begin
                    r_i <= r_i + IW'(1);
                    r_s <= '0;
                end else begin
                    r_s <= r_s + IW'(1);
                end
            end
        end
    end

endmodule

// File: sv/tgs_lane.sv
`timescale 1ns / 1ps
// one coordinate of one grid point, six register stages with a common enable
// depends on tgs_pkg

module tgs_lane #(
    parameter int COORD_BITS = tgs_pkg::COORD_BITS,
    parameter int MAX_DETAIL = tgs_pkg::MAX_DETAIL
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_BITS-1:0]  i_a,
    input  logic signed [COORD_BITS-1:0]  i_b,
    input  logic signed [COORD_BITS-1:0]  i_c,
    input  logic [MAX_DETAIL:0]           i_pt_i,
    input  logic [MAX_DETAIL:0]           i_pt_j,
    input  logic [tgs_pkg::DET_BITS-1:0]  i_det,
    output logic signed [COORD_BITS-1:0]  o_res
);

    localparam int CW = COORD_BITS;
    localparam int DW = tgs_pkg::DET_BITS;
    localparam int IW = MAX_DETAIL + 1;
    localparam int PW = CW + IW + 2;
    localparam int NW = PW + 1;

    // stage 1: captured inputs
    logic signed [CW-1:0] r1_a, r1_b, r1_c;
    logic [IW-1:0]        r1_i, r1_j;
    logic [DW-1:0]        r1_det;
    // stage 2: row-end products
    logic signed [PW-1:0] r2_pa, r2_pb;
    logic signed [CW-1:0] r2_a, r2_b;
    logic [IW-1:0]        r2_j, r2_rows;
    logic [DW-1:0]        r2_det;
    // stage 3: row ends
    logic signed [CW-1:0] r3_ra, r3_rb;
    logic [IW-1:0]        r3_j, r3_rows;
    // stage 4: point numerator
    logic signed [PW-1:0] r4_n;
    logic signed [CW-1:0] r4_ra;
    logic [IW-1:0]        r4_rows;
    // stage 5: quotient estimate
    logic [NW-1:0]        r5_q0, r5_num;
    logic [IW:0]          r5_den;
    logic                 r5_neg;
    logic signed [CW-1:0] r5_ra;
    // stage 6: result
    logic signed [CW-1:0] r6_res;

    logic signed [CW:0]   n_da, n_db, n_dr;
    logic signed [PW-1:0] n_pa, n_pb, n_n;
    logic [IW-1:0]        n_cols2, n_rows, n_cols3;
    logic [DW:0]          n_sh;
    logic [PW-1:0]        n_mag_a, n_mag_b, n_mag;
    logic [PW:0]          n_ta, n_tb;
    logic signed [CW+1:0] n_qa, n_qb, n_ra_w, n_rb_w;
    logic [NW-1:0]        n_num, n_m, n_q0, n_qd, n_r, n_q;
    logic [2*NW-1:0]      n_prod;
    logic signed [CW+1:0] n_qs, n_res_w;

    always_comb begin
        // stage 2: (c-a)*i, (c-b)*i and the row length
        n_da    = $signed({r1_c[CW-1], r1_c}) - $signed({r1_a[CW-1], r1_a});
        n_db    = $signed({r1_c[CW-1], r1_c}) - $signed({r1_b[CW-1], r1_b});
        n_pa    = n_da * $signed({1'b0, r1_i});
        n_pb    = n_db * $signed({1'b0, r1_i});
        n_cols2 = IW'(1) << r1_det;
        n_rows  = n_cols2 - r1_i;
        // apex row: the point is the row end, any divisor gives zero
        if (n_rows == '0) begin
            n_rows = IW'(1);
        end

        // stage 3: round by the power-of-two column count, ties away from zero
        n_cols3 = IW'(1) << r2_det;
        n_sh    = {1'b0, r2_det} + (DW+1)'(1);
        n_mag_a = r2_pa[PW-1] ? PW'(-r2_pa) : PW'(r2_pa);
        n_mag_b = r2_pb[PW-1] ? PW'(-r2_pb) : PW'(r2_pb);
        n_ta    = ({n_mag_a, 1'b0} + (PW+1)'(n_cols3)) >> n_sh;
        n_tb    = ({n_mag_b, 1'b0} + (PW+1)'(n_cols3)) >> n_sh;
        n_qa    = $signed({1'b0, n_ta[CW:0]});
        n_qb    = $signed({1'b0, n_tb[CW:0]});
        n_ra_w  = $signed({{2{r2_a[CW-1]}}, r2_a}) + (r2_pa[PW-1] ? -n_qa : n_qa);
        n_rb_w  = $signed({{2{r2_b[CW-1]}}, r2_b}) + (r2_pb[PW-1] ? -n_qb : n_qb);

        // stage 4: (rb-ra)*j
        n_dr = $signed({r3_rb[CW-1], r3_rb}) - $signed({r3_ra[CW-1], r3_ra});
        n_n  = n_dr * $signed({1'b0, r3_j});

        // stage 5: floor((2|n|+rows)/(2rows)) by reciprocal, may be one short
        n_mag  = r4_n[PW-1] ? PW'(-r4_n) : PW'(r4_n);
        n_num  = {n_mag, 1'b0} + NW'(r4_rows);
        n_m    = NW'(tgs_pkg::f_recip(8'(r4_rows), NW));
        n_prod = n_num * n_m;
        n_q0   = n_prod[2*NW-1:NW];

        // stage 6: correct the estimate and apply the sign
        n_qd    = r5_q0 * NW'(r5_den);
        n_r     = r5_num - n_qd;
        n_q     = (n_r >= NW'(r5_den)) ? r5_q0 + NW'(1) : r5_q0;
        n_qs    = $signed({1'b0, n_q[CW:0]});
        n_res_w = $signed({{2{r5_ra[CW-1]}}, r5_ra}) + (r5_neg ? -n_qs : n_qs);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a    <= i_a;
            r1_b    <= i_b;
            r1_c    <= i_c;
            r1_i    <= i_pt_i;
            r1_j    <= i_pt_j;
            r1_det  <= i_det;

            r2_pa   <= n_pa;
            r2_pb   <= n_pb;
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r2_j    <= r1_j;
            r2_rows <= n_rows;
            r2_det  <= r1_det;

            r3_ra   <= n_ra_w[CW-1:0];
            r3_rb   <= n_rb_w[CW-1:0];
            r3_j    <= r2_j;
            r3_rows <= r2_rows;

            r4_n    <= n_n;
            r4_ra   <= r3_ra;
            r4_rows <= r3_rows;

            r5_q0   <= n_q0;
            r5_num  <= n_num;
            r5_den  <= {r4_rows, 1'b0};
            r5_neg  <= r4_n[PW-1];
            r5_ra   <= r4_ra;

            r6_res  <= n_res_w[CW-1:0];
        end
    end

    assign o_res = r6_res;

endmodule

// File: sv/triangle_grid_subdivider.sv
`timescale 1ns / 1ps
// triangle grid subdivider top level: sequencer, nine coordinate lanes, valid chain
// depends on tgs_pkg, tgs_if, tgs_seq, tgs_lane
//
//   channel   dir   handshake      payload
//   i_tri     in    valid/ready    corners a, b, c (x, y, z each)
//   o_sub     out   valid/ready    p0, p1, p2 (x, y, z each), last_of_face
//   i_cfg     in    write enable   detail_level
//
// one triangle gives 4^detail_level sub-triangles (1 to 64), issued one per cycle by
// the sequencer while o_sub is not stalled; the next triangle is taken in the cycle
// its last sub-triangle issues.
// reset is synchronous and clears the sequencer, the valid chain and detail_level.
// a stall on o_sub freezes every stage together, so nothing is lost or repeated.

module triangle_grid_subdivider #(
    parameter int COORD_BITS = tgs_pkg::COORD_BITS,
    parameter int MAX_DETAIL = tgs_pkg::MAX_DETAIL
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [tgs_pkg::DET_BITS-1:0]  i_cfg_wr_data,
    tgs_tri_if.sink                       i_tri,
    tgs_sub_if.source                     o_sub
);

    localparam int DEPTH = 6;

    logic                          w_adv;
    logic                          w_issue;
    logic                          w_last;
    logic [tgs_pkg::DET_BITS-1:0]  w_det;
    logic signed [COORD_BITS-1:0]  w_a [3];
    logic signed [COORD_BITS-1:0]  w_b [3];
    logic signed [COORD_BITS-1:0]  w_c [3];
    logic [MAX_DETAIL:0]           w_pt_i [3];
    logic [MAX_DETAIL:0]           w_pt_j [3];
    logic signed [COORD_BITS-1:0]  w_res [9];

    logic [DEPTH-1:0] r_v;
    logic [DEPTH-1:0] r_last;

    assign w_adv = !r_v[DEPTH-1] || o_sub.ready;

    tgs_seq #(
        .COORD_BITS (COORD_BITS),
        .MAX_DETAIL (MAX_DETAIL)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_tri         (i_tri),
        .i_adv         (w_adv),
        .o_issue       (w_issue),
        .o_last        (w_last),
        .o_det         (w_det),
        .o_a           (w_a),
        .o_b           (w_b),
        .o_c           (w_c),
        .o_pt_i        (w_pt_i),
        .o_pt_j        (w_pt_j)
    );

    // lane g handles vertex g/3, axis g%3
    for (genvar g = 0; g < 9; g++) begin : g_lane
        tgs_lane #(
            .COORD_BITS (COORD_BITS),
            .MAX_DETAIL (MAX_DETAIL)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_a    (w_a[g % 3]),
            .i_b    (w_b[g % 3]),
            .i_c    (w_c[g % 3]),
            .i_pt_i (w_pt_i[g / 3]),
            .i_pt_j (w_pt_j[g / 3]),
            .i_det  (w_det),
            .o_res  (w_res[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v    <= {r_v[DEPTH-2:0], w_issue};
            r_last <= {r_last[DEPTH-2:0], w_last};
        end
    end

    assign o_sub.valid        = r_v[DEPTH-1];
    assign o_sub.last_of_face = r_last[DEPTH-1];
    assign o_sub.p0_x         = w_res[0];
    assign o_sub.p0_y         = w_res[1];
    assign o_sub.p0_z         = w_res[2];
    assign o_sub.p1_x         = w_res[3];
    assign o_sub.p1_y         = w_res[4];
    assign o_sub.p1_z         = w_res[5];
    assign o_sub.p2_x         = w_res[6];
    assign o_sub.p2_y         = w_res[7];
    assign o_sub.p2_z         = w_res[8];

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// testbench for triangle_grid_subdivider: random and corner triangles at every detail level
// depends on tgs_pkg, tgs_if and the subdivider rtl

typedef logic signed [15:0] t_coord;

typedef struct packed {
    t_coord p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
    logic   last;
} t_subtri;

class subtri_scoreboard;
    t_subtri pending[$];
    int unsigned mismatches;
    logic [1:0] detail;

    // quotient rounded to nearest, ties away from zero
    function automatic longint round_div(longint n, longint d);
        longint mag;
        mag = (n < 0) ? -n : n;
        mag = (2 * mag + d) / (2 * d);
        return (n < 0) ? -mag : mag;
    endfunction

    function automatic void note_triangle(t_coord in_c[9]);
        longint pts[9][9][3];
        longint ra, rb;
        int cols, rows, n;
        t_subtri t;
        cols = 1 << detail;
        for (int i = 0; i <= cols; i++) begin
            rows = cols - i;
            for (int ax = 0; ax < 3; ax++) begin
                ra = in_c[ax] + round_div((in_c[6+ax] - in_c[ax]) * i, cols);
                rb = in_c[3+ax] + round_div((in_c[6+ax] - in_c[3+ax]) * i, cols);
                if (rows == 0) pts[i][0][ax] = ra;
                else
                    for (int j = 0; j <= rows; j++)
                        pts[i][j][ax] = ra + round_div((rb - ra) * j, rows);
            end
        end
        n = 0;
        for (int i = 0; i < cols; i++) begin
            for (int s = 0; s < 2 * (cols - i) - 1; s++) begin
                int k;
                int r1, c1, r2, c2;
                k = s / 2;
                if ((s & 1) == 0) begin
                    r1 = i + 1; c1 = k; r2 = i; c2 = k;
                end else begin
                    r1 = i + 1; c1 = k + 1; r2 = i + 1; c2 = k;
                end
                t.p0_x = t_coord'(pts[i][k+1][0]);
                t.p0_y = t_coord'(pts[i][k+1][1]);
                t.p0_z = t_coord'(pts[i][k+1][2]);
                t.p1_x = t_coord'(pts[r1][c1][0]);
                t.p1_y = t_coord'(pts[r1][c1][1]);
                t.p1_z = t_coord'(pts[r1][c1][2]);
                t.p2_x = t_coord'(pts[r2][c2][0]);
                t.p2_y = t_coord'(pts[r2][c2][1]);
                t.p2_z = t_coord'(pts[r2][c2][2]);
                n++;
                t.last = (n == cols * cols);
                pending.push_back(t);
            end
        end
    endfunction

    function automatic void check_subtri(t_subtri got);
        t_subtri want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected sub-triangle %h", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %h got %h", want, got);
        end
    endfunction
endclass

module tb;
    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [1:0] i_cfg_wr_data;
    tgs_tri_if tri_ch ();
    tgs_sub_if sub_ch ();

    triangle_grid_subdivider i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data), .i_tri(tri_ch.sink), .o_sub(sub_ch.source)
    );

    subtri_scoreboard sb;
    int send_idle_pct, recv_idle_pct;
    longint cycles;
    bit drained;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 2000000) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver: ready toggles at the falling edge, transfers sampled at the rising edge
    initial begin
        t_subtri got;
        sub_ch.ready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && sub_ch.valid && sub_ch.ready) begin
                got = {sub_ch.p0_x, sub_ch.p0_y, sub_ch.p0_z, sub_ch.p1_x, sub_ch.p1_y,
                       sub_ch.p1_z, sub_ch.p2_x, sub_ch.p2_y, sub_ch.p2_z, sub_ch.last_of_face};
                sb.check_subtri(got);
            end
            @(negedge i_clk);
            sub_ch.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_coord pick_coord();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return t_coord'(0);
            default: return t_coord'($urandom);
        endcase
    endfunction

    task automatic send_triangle(t_coord c[9]);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        tri_ch.valid = 1;
        {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z} = {c[0], c[1], c[2]};
        {tri_ch.b_x, tri_ch.b_y, tri_ch.b_z} = {c[3], c[4], c[5]};
        {tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} = {c[6], c[7], c[8]};
        do @(posedge i_clk); while (!tri_ch.ready);
        sb.note_triangle(c);
        @(negedge i_clk);
        tri_ch.valid = 0;
    endtask

    task automatic set_detail(logic [1:0] d);
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        i_cfg_wr_en = 1;
        i_cfg_wr_data = d;
        sb.detail = d;
        @(negedge i_clk);
        i_cfg_wr_en = 0;
    endtask

    initial begin
        t_coord c[9];
        sb = new();
        sb.detail = 2'd0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 0;
        i_cfg_wr_en = 0;
        i_cfg_wr_data = 2'd0;
        tri_ch.valid = 0;
        {tri_ch.a_x, tri_ch.a_y, tri_ch.a_z, tri_ch.b_x, tri_ch.b_y, tri_ch.b_z,
         tri_ch.c_x, tri_ch.c_y, tri_ch.c_z} = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;

        // directed corners at every detail level, reset level first
        for (int d = 0; d < 4; d++) begin
            if (d != 0) set_detail(2'(d));
            for (int k = 0; k < 9; k++) c[k] = (k < 6) ? 16'sh8000 : 16'sh7fff;
            send_triangle(c);
            for (int k = 0; k < 9; k++) c[k] = (k < 6) ? 16'sh7fff : 16'sh8000;
            send_triangle(c);
            for (int k = 0; k < 9; k++) c[k] = (k % 2) ? 16'sh7fff : 16'sh8000;
            send_triangle(c);
            for (int k = 0; k < 9; k++) c[k] = t_coord'(k - 4);
            send_triangle(c);
            for (int k = 0; k < 9; k++) c[k] = pick_coord();
            send_triangle(c);
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 88 : 0;
            recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 17 : 0;
            for (int blk = 0; blk < 4; blk++) begin
                set_detail(2'($urandom_range(3)));
                for (int n = 0; n < 37; n++) begin
                    for (int k = 0; k < 9; k++) c[k] = pick_coord();
                    send_triangle(c);
                end
            end
        end

        drained = 0;
        while (!drained) begin
            @(negedge i_clk);
            drained = (sb.pending.size() == 0);
        end
        repeat (20) @(negedge i_clk);
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
